// File: hdl/oale_pkg.sv
package oale_pkg;

    // List geometry
    localparam int LIST_DEPTH = 64;
    localparam int ADDR_W     = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    // Field widths
    localparam int OP_W   = 3;
    localparam int WORD_W = 32;
    localparam int POS_W  = 7;
    localparam int STAT_W = 2;

    // Compare width wide enough for position, count and count + 1
    localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    // Opcodes
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
    localparam logic [OP_W-1:0] OP_READ   = 3'd2;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd4;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS   = 2'd3;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_COUNT,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_POS,
        RD_IDX,
        RD_IDX_M1
    } rd_sel_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_TAIL_VAL,
        WR_POS_VAL,
        WR_UP_RDATA,
        WR_DOWN_RDATA
    } wr_sel_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CLR,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef struct packed {
        logic              item_load;
        logic              res_clear;
        logic              stat_load;
        logic [STAT_W-1:0] stat_code;
        logic              data_load;
        logic              found_load;
        logic              out_load;
        idx_op_t           idx_op;
        rd_sel_t           rd_sel;
        wr_sel_t           wr_sel;
        cnt_op_t           cnt_op;
    } dp_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] opcode;
        logic            full;
        logic            rd_pos_ok;
        logic            ins_pos_ok;
        logic            idx_ge_pos;
        logic            idx_lt_cnt;
        logic            pend;
        logic            match;
    } dp_stat_t;

endpackage

// File: hdl/ordered_array_list_engine.sv
// Channel   Direction  Beat contents
// -------   ---------  ----------------------------------------------------------
// s_        in         tuser: opcode; tdata: value, position
// m_        out        tuser: status; tdata: data_out, found_position, list_count
//
// One item is handled at a time, from the accept cycle through the output register load.
// Clear, append, spare and rejected items go from decode straight to finish; read waits
// for its entry; search walks from the head; delete walks to the match, then shifts the
// tail down; insert shifts the tail up from the end to the position. Walks go over the
// single-write, single-read entry memory one entry per cycle. Reset clears the count,
// the controller and the output valid; entries keep whatever they hold. The next beat is
// taken while a result still waits on m_; the finished result then holds until m_ drains.
module ordered_array_list_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // [31:0] value, [38:32] position, [39] zero
    input  logic [2:0]  s_tuser,  // [2:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,  // [31:0] data_out, [38:32] found_position,
                                  // [45:39] list_count, [47:46] zero
    output logic [1:0]  m_tuser   // [1:0] status
);

    oale_pkg::dp_cmd_t  cmd;
    oale_pkg::dp_stat_t stat;

    // Unpacked beat fields
    logic        [oale_pkg::OP_W-1:0]   s_opcode;
    logic signed [oale_pkg::WORD_W-1:0] s_value;
    logic        [oale_pkg::POS_W-1:0]  s_position;
    logic        [oale_pkg::STAT_W-1:0] m_status;
    logic signed [oale_pkg::WORD_W-1:0] m_data_out;
    logic        [oale_pkg::POS_W-1:0]  m_found_position;
    logic        [oale_pkg::POS_W-1:0]  m_list_count;

    assign s_opcode   = s_tuser;
    assign s_value    = s_tdata[31:0];
    assign s_position = s_tdata[38:32];

    // Sequence each opcode: decode, walk, then hand the result to the output register
    oale_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold the entries, count, walk pointer and result registers
    oale_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .s_opcode         (s_opcode),
        .s_value          (s_value),
        .s_position       (s_position),
        .m_status         (m_status),
        .m_data_out       (m_data_out),
        .m_found_position (m_found_position),
        .m_list_count     (m_list_count)
    );

    // Pack the result beat, pad bits driven to zero
    assign m_tdata = {2'b00, m_list_count, m_found_position, m_data_out};
    assign m_tuser = m_status;

`ifndef NO_ASSERTIONS
    // The engine works on one beat at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in progress");

    // Count never passes the list depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[45:39] <= oale_pkg::LIST_DEPTH))
        else $error("list count above depth");

    // A match position only comes with ok status and lies at most one past the list count
    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[38:32] != 7'd0)) |->
        ((m_tuser == oale_pkg::ST_OK) && (m_tdata[38:32] <= m_tdata[45:39] + 1)))
        else $error("found position without ok status or beyond list");

    // Read data is zero unless the status is ok
    a_data_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != oale_pkg::ST_OK)) |-> (m_tdata[31:0] == 32'd0))
        else $error("nonzero data with error status");
`endif

endmodule

// File: hdl/oale_dp.sv
module oale_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  oale_pkg::dp_cmd_t                    cmd,
    output oale_pkg::dp_stat_t                   stat,
    input  logic        [oale_pkg::OP_W-1:0]     s_opcode,
    input  logic signed [oale_pkg::WORD_W-1:0]   s_value,
    input  logic        [oale_pkg::POS_W-1:0]    s_position,
    output logic        [oale_pkg::STAT_W-1:0]   m_status,
    output logic signed [oale_pkg::WORD_W-1:0]   m_data_out,
    output logic        [oale_pkg::POS_W-1:0]    m_found_position,
    output logic        [oale_pkg::POS_W-1:0]    m_list_count
);

    // Item registers
    logic        [oale_pkg::OP_W-1:0]   op_reg;
    logic signed [oale_pkg::WORD_W-1:0] val_reg;
    logic        [oale_pkg::POS_W-1:0]  pos_reg;

    // Walk state
    logic [oale_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [oale_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic                       pend_reg;

    // Entry store
    logic signed [oale_pkg::WORD_W-1:0] entry_mem [oale_pkg::LIST_DEPTH];
    logic signed [oale_pkg::WORD_W-1:0] rdata_reg;

    // Result in progress and output holding register
    logic        [oale_pkg::STAT_W-1:0] status_reg;
    logic signed [oale_pkg::WORD_W-1:0] data_reg;
    logic        [oale_pkg::POS_W-1:0]  found_reg;
    logic        [oale_pkg::STAT_W-1:0] out_status_reg;
    logic signed [oale_pkg::WORD_W-1:0] out_data_reg;
    logic        [oale_pkg::POS_W-1:0]  out_found_reg;
    logic        [oale_pkg::POS_W-1:0]  out_count_reg;

    logic [oale_pkg::CNT_W-1:0] idx_p1, idx_m1, idx_m2;
    logic [oale_pkg::POS_W-1:0] pos_m1;
    logic [oale_pkg::CMP_W-1:0] pos_x, cnt_x, idx_x;

    logic                               rd_en, wr_en;
    logic        [oale_pkg::ADDR_W-1:0] rd_addr, wr_addr;
    logic signed [oale_pkg::WORD_W-1:0] wr_data;

    assign idx_p1 = idx_reg + oale_pkg::CNT_W'(1);
    assign idx_m1 = idx_reg - oale_pkg::CNT_W'(1);
    assign idx_m2 = idx_reg - oale_pkg::CNT_W'(2);
    assign pos_m1 = pos_reg - oale_pkg::POS_W'(1);

    assign pos_x = oale_pkg::CMP_W'(pos_reg);
    assign cnt_x = oale_pkg::CMP_W'(cnt_reg);
    assign idx_x = oale_pkg::CMP_W'(idx_reg);

    always_comb begin
        stat.opcode     = op_reg;
        stat.full       = (cnt_reg == oale_pkg::CNT_W'(oale_pkg::LIST_DEPTH));
        stat.rd_pos_ok  = (pos_reg != '0) && (pos_x <= cnt_x);
        stat.ins_pos_ok = (pos_reg != '0) && (pos_x <= cnt_x + oale_pkg::CMP_W'(1));
        stat.idx_ge_pos = (idx_x >= pos_x);
        stat.idx_lt_cnt = (idx_reg < cnt_reg);
        stat.pend       = pend_reg;
        stat.match      = (rdata_reg == val_reg);
    end

    always_comb begin
        rd_en   = 1'b1;
        rd_addr = idx_reg[oale_pkg::ADDR_W-1:0];
        unique case (cmd.rd_sel)
            oale_pkg::RD_NONE:   rd_en   = 1'b0;
            oale_pkg::RD_POS:    rd_addr = pos_m1[oale_pkg::ADDR_W-1:0];
            oale_pkg::RD_IDX:    rd_addr = idx_reg[oale_pkg::ADDR_W-1:0];
            oale_pkg::RD_IDX_M1: rd_addr = idx_m1[oale_pkg::ADDR_W-1:0];
            default:             rd_en   = 1'b0;
        endcase
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = cnt_reg[oale_pkg::ADDR_W-1:0];
        wr_data = val_reg;
        unique case (cmd.wr_sel)
            oale_pkg::WR_NONE: wr_en = 1'b0;
            oale_pkg::WR_TAIL_VAL: begin
                wr_addr = cnt_reg[oale_pkg::ADDR_W-1:0];
                wr_data = val_reg;
            end
            oale_pkg::WR_POS_VAL: begin
                wr_addr = pos_m1[oale_pkg::ADDR_W-1:0];
                wr_data = val_reg;
            end
            oale_pkg::WR_UP_RDATA: begin
                wr_addr = idx_p1[oale_pkg::ADDR_W-1:0];
                wr_data = rdata_reg;
            end
            oale_pkg::WR_DOWN_RDATA: begin
                wr_addr = idx_m2[oale_pkg::ADDR_W-1:0];
                wr_data = rdata_reg;
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_comb begin
        unique case (cmd.idx_op)
            oale_pkg::IDX_HOLD:  idx_next = idx_reg;
            oale_pkg::IDX_ZERO:  idx_next = '0;
            oale_pkg::IDX_COUNT: idx_next = cnt_reg;
            oale_pkg::IDX_INC:   idx_next = idx_p1;
            oale_pkg::IDX_DEC:   idx_next = idx_m1;
            default:             idx_next = idx_reg;
        endcase
    end

    always_comb begin
        unique case (cmd.cnt_op)
            oale_pkg::CNT_HOLD: cnt_next = cnt_reg;
            oale_pkg::CNT_CLR:  cnt_next = '0;
            oale_pkg::CNT_INC:  cnt_next = cnt_reg + oale_pkg::CNT_W'(1);
            oale_pkg::CNT_DEC:  cnt_next = cnt_reg - oale_pkg::CNT_W'(1);
            default:            cnt_next = cnt_reg;
        endcase
    end

    // One write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= entry_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            pend_reg <= rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (cmd.item_load) begin
            op_reg  <= s_opcode;
            val_reg <= s_value;
            pos_reg <= s_position;
        end
        if (cmd.res_clear) begin
            status_reg <= oale_pkg::ST_OK;
            data_reg   <= '0;
            found_reg  <= '0;
        end else begin
            if (cmd.stat_load) begin
                status_reg <= cmd.stat_code;
            end
            if (cmd.data_load) begin
                data_reg <= rdata_reg;
            end
            if (cmd.found_load) begin
                found_reg <= oale_pkg::POS_W'(idx_reg);
            end
        end
        if (cmd.out_load) begin
            out_status_reg <= status_reg;
            out_data_reg   <= data_reg;
            out_found_reg  <= found_reg;
            out_count_reg  <= oale_pkg::POS_W'(cnt_reg);
        end
    end

    assign m_status         = out_status_reg;
    assign m_data_out       = out_data_reg;
    assign m_found_position = out_found_reg;
    assign m_list_count     = out_count_reg;

endmodule

// File: hdl/oale_ctrl.sv
module oale_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  oale_pkg::dp_stat_t stat,
    output oale_pkg::dp_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DECODE    = 3'd1;
    localparam logic [2:0] S_RD_WAIT   = 3'd2;
    localparam logic [2:0] S_SCAN      = 3'd3;
    localparam logic [2:0] S_INS_SHIFT = 3'd4;
    localparam logic [2:0] S_DEL_SHIFT = 3'd5;
    localparam logic [2:0] S_FINISH    = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.stat_code  = oale_pkg::ST_OK;
        cmd.idx_op     = oale_pkg::IDX_HOLD;
        cmd.rd_sel     = oale_pkg::RD_NONE;
        cmd.wr_sel     = oale_pkg::WR_NONE;
        cmd.cnt_op     = oale_pkg::CNT_HOLD;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.item_load = 1'b1;
                    cmd.res_clear = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next    = S_FINISH;
                unique case (stat.opcode)
                    oale_pkg::OP_CLEAR: cmd.cnt_op = oale_pkg::CNT_CLR;
                    oale_pkg::OP_APPEND: begin
                        if (stat.full) begin
                            cmd.stat_load = 1'b1;
                            cmd.stat_code = oale_pkg::ST_FULL;
                        end else begin
                            cmd.wr_sel = oale_pkg::WR_TAIL_VAL;
                            cmd.cnt_op = oale_pkg::CNT_INC;
                        end
                    end
                    oale_pkg::OP_READ: begin
                        if (stat.rd_pos_ok) begin
                            cmd.rd_sel = oale_pkg::RD_POS;
                            state_next = S_RD_WAIT;
                        end else begin
                            cmd.stat_load = 1'b1;
                            cmd.stat_code = oale_pkg::ST_BADPOS;
                        end
                    end
                    oale_pkg::OP_INSERT: begin
                        priority if (stat.full) begin
                            cmd.stat_load = 1'b1;
                            cmd.stat_code = oale_pkg::ST_FULL;
                        end else if (!stat.ins_pos_ok) begin
                            cmd.stat_load = 1'b1;
                            cmd.stat_code = oale_pkg::ST_BADPOS;
                        end else begin
                            cmd.idx_op = oale_pkg::IDX_COUNT;
                            state_next = S_INS_SHIFT;
                        end
                    end
                    oale_pkg::OP_DELETE, oale_pkg::OP_SEARCH: begin
                        cmd.idx_op = oale_pkg::IDX_ZERO;
                        state_next = S_SCAN;
                    end
                    default: state_next = S_FINISH;
                endcase
            end
            S_RD_WAIT: begin
                cmd.data_load = 1'b1;
                state_next    = S_FINISH;
            end
            S_SCAN: begin
                priority if (stat.pend && stat.match) begin
                    cmd.found_load = 1'b1;
                    state_next     = (stat.opcode == oale_pkg::OP_DELETE) ? S_DEL_SHIFT
                                                                         : S_FINISH;
                end else if (stat.idx_lt_cnt) begin
                    cmd.rd_sel = oale_pkg::RD_IDX;
                    cmd.idx_op = oale_pkg::IDX_INC;
                end else begin
                    // walked past the last entry without a hit
                    cmd.stat_load = 1'b1;
                    cmd.stat_code = oale_pkg::ST_NOTFOUND;
                    state_next    = S_FINISH;
                end
            end
            S_INS_SHIFT: begin
                priority if (stat.idx_ge_pos) begin
                    cmd.rd_sel = oale_pkg::RD_IDX_M1;
                    cmd.idx_op = oale_pkg::IDX_DEC;
                    if (stat.pend) begin
                        cmd.wr_sel = oale_pkg::WR_UP_RDATA;
                    end
                end else if (stat.pend) begin
                    cmd.wr_sel = oale_pkg::WR_UP_RDATA;
                end else begin
                    cmd.wr_sel = oale_pkg::WR_POS_VAL;
                    cmd.cnt_op = oale_pkg::CNT_INC;
                    state_next = S_FINISH;
                end
            end
            S_DEL_SHIFT: begin
                priority if (stat.idx_lt_cnt) begin
                    cmd.rd_sel = oale_pkg::RD_IDX;
                    cmd.idx_op = oale_pkg::IDX_INC;
                    if (stat.pend) begin
                        cmd.wr_sel = oale_pkg::WR_DOWN_RDATA;
                    end
                end else if (stat.pend) begin
                    cmd.wr_sel = oale_pkg::WR_DOWN_RDATA;
                end else begin
                    cmd.cnt_op = oale_pkg::CNT_DEC;
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        priority if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: bench/ordered_array_list_engine_tb.sv
`timescale 1ns / 100ps

module ordered_array_list_engine_tb;

    // Opcodes with no function: the block must leave the list alone
    localparam logic [oale_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [oale_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

    // Two copies of the list: one steers the stimulus, one predicts results
    localparam int GEN_SIDE = 0;
    localparam int CHK_SIDE = 1;

    localparam int CYCLE_LIMIT   = 500_000;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 80;
    localparam int CALM_TAIL     = 80;
    localparam int RANDOM_ITEMS  = 650;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [oale_pkg::OP_W-1:0]   op;
        logic [oale_pkg::WORD_W-1:0] value;
        logic [oale_pkg::POS_W-1:0]  pos;
    } list_item_t;

    typedef struct packed {
        logic [oale_pkg::STAT_W-1:0] status;
        logic [oale_pkg::WORD_W-1:0] data;
        logic [oale_pkg::POS_W-1:0]  found;
        logic [oale_pkg::POS_W-1:0]  count;
    } list_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;  // [31:0] value, [38:32] position, [39] zero
    logic [2:0]  s_tuser  = '0;  // [2:0] opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // [31:0] data_out, [38:32] found_position,
                                 // [45:39] list_count, [47:46] zero
    logic [1:0]  m_tuser;        // [1:0] status

    ordered_array_list_engine u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // List state, one copy per side
    logic [oale_pkg::WORD_W-1:0] shadow_words [2][oale_pkg::LIST_DEPTH];
    int unsigned                 shadow_len   [2];

    list_item_t   stim_queue[$];     // beats waiting to be offered
    list_result_t result_queue[$];   // results owed by the block, oldest first

    int unsigned stim_total     = 0;
    int unsigned accepted_beats = 0;
    int unsigned checked_beats  = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned peak_len       = 0;
    int unsigned status_seen[4] = '{0, 0, 0, 0};
    bit          offer_open     = 1'b0;
    bit          hold_off       = 1'b0;

    // Apply one operation to one copy of the list and return what it reports.
    function automatic list_result_t list_apply(input int side, input list_item_t it);
        list_result_t r;
        int           i;
        int           k;
        int           len;
        r   = '0;
        len = shadow_len[side];
        case (it.op)
            oale_pkg::OP_CLEAR: begin
                len = 0;
            end
            oale_pkg::OP_APPEND: begin
                if (len >= oale_pkg::LIST_DEPTH) begin
                    r.status = oale_pkg::ST_FULL;
                end else begin
                    shadow_words[side][len] = it.value;
                    len++;
                end
            end
            oale_pkg::OP_READ: begin
                if (it.pos >= 1 && int'(it.pos) <= len)
                    r.data = shadow_words[side][it.pos - 1];
                else
                    r.status = oale_pkg::ST_BADPOS;
            end
            oale_pkg::OP_INSERT: begin
                if (len >= oale_pkg::LIST_DEPTH) begin
                    // full wins over a bad position
                    r.status = oale_pkg::ST_FULL;
                end else if (it.pos < 1 || int'(it.pos) > len + 1) begin
                    r.status = oale_pkg::ST_BADPOS;
                end else begin
                    // shift the tail up by one, then drop the word in
                    for (i = len; i >= int'(it.pos); i--)
                        shadow_words[side][i] = shadow_words[side][i - 1];
                    shadow_words[side][it.pos - 1] = it.value;
                    len++;
                end
            end
            oale_pkg::OP_DELETE, oale_pkg::OP_SEARCH: begin
                k = -1;
                for (i = 0; i < len && k < 0; i++)
                    if (shadow_words[side][i] == it.value)
                        k = i;
                if (k < 0) begin
                    r.status = oale_pkg::ST_NOTFOUND;
                end else begin
                    r.found = oale_pkg::POS_W'(k + 1);
                    if (it.op == oale_pkg::OP_DELETE) begin
                        // close the gap left by the first match
                        for (i = k; i + 1 < len; i++)
                            shadow_words[side][i] = shadow_words[side][i + 1];
                        len--;
                    end
                end
            end
            default: begin
                // spare opcodes: report ok with the count, change nothing
            end
        endcase
        shadow_len[side] = len;
        r.count = oale_pkg::POS_W'(len);
        return r;
    endfunction

    // Queue one beat and advance the steering copy with it.
    task automatic add_item(input logic [oale_pkg::OP_W-1:0]   op,
                            input logic [oale_pkg::WORD_W-1:0] val,
                            input logic [oale_pkg::POS_W-1:0]  pos);
        list_item_t it;
        it = '{op: op, value: val, pos: pos};
        void'(list_apply(GEN_SIDE, it));
        stim_queue.push_back(it);
    endtask

    // Mostly small or already stored words so that search and delete hit.
    function automatic logic [oale_pkg::WORD_W-1:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 3 && shadow_len[GEN_SIDE] > 0)
            return shadow_words[GEN_SIDE][$urandom_range(0, shadow_len[GEN_SIDE] - 1)];
        else if (sel < 7)
            return oale_pkg::WORD_W'($urandom_range(0, 15)) - 32'd8;
        else
            return $urandom;
    endfunction

    // Mostly legal positions, some at the edges, a few anywhere in 7 bits.
    function automatic logic [oale_pkg::POS_W-1:0] pick_pos(
        input logic [oale_pkg::OP_W-1:0] op);
        int unsigned lim;
        int unsigned sel;
        lim = (op == oale_pkg::OP_INSERT) ? shadow_len[GEN_SIDE] + 1 : shadow_len[GEN_SIDE];
        sel = $urandom_range(0, 9);
        if (sel < 7 && lim > 0)
            return oale_pkg::POS_W'($urandom_range(1, lim));
        else if (sel < 9)
            return oale_pkg::POS_W'($urandom_range(0, lim + 1));
        else
            return oale_pkg::POS_W'($urandom_range(0, 127));
    endfunction

    task automatic add_fill_run();
        logic [oale_pkg::WORD_W-1:0] v;
        // fill to the brim, then poke at the full list
        while (shadow_len[GEN_SIDE] < oale_pkg::LIST_DEPTH)
            add_item(oale_pkg::OP_APPEND, pick_value(),
                     oale_pkg::POS_W'($urandom_range(0, 127)));
        add_item(oale_pkg::OP_APPEND, $urandom, '0);
        add_item(oale_pkg::OP_INSERT, $urandom, 7'd1);
        add_item(oale_pkg::OP_INSERT, $urandom, 7'd0);
        add_item(oale_pkg::OP_READ, '0, 7'd64);
        add_item(oale_pkg::OP_READ, '0, 7'd65);
        v = shadow_words[GEN_SIDE][oale_pkg::LIST_DEPTH - 1];
        add_item(oale_pkg::OP_SEARCH, v, '0);
        add_item(oale_pkg::OP_DELETE, shadow_words[GEN_SIDE][0], '0);
        // longest walk: insert at the head of a 63-entry list
        add_item(oale_pkg::OP_INSERT, pick_value(), 7'd1);
        add_item(oale_pkg::OP_INSERT, pick_value(), 7'd64);
        add_item(oale_pkg::OP_DELETE, v, '0);
        add_item(oale_pkg::OP_INSERT, pick_value(), 7'd64);
    endtask

    task automatic add_mixed_run(input int unsigned n);
        int unsigned                r;
        logic [oale_pkg::OP_W-1:0]  op;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 25)      op = oale_pkg::OP_APPEND;
            else if (r < 45) op = oale_pkg::OP_INSERT;
            else if (r < 60) op = oale_pkg::OP_READ;
            else if (r < 75) op = oale_pkg::OP_SEARCH;
            else if (r < 94) op = oale_pkg::OP_DELETE;
            else if (r < 96) op = oale_pkg::OP_CLEAR;
            else if (r < 98) op = OP_SPARE_6;
            else             op = OP_SPARE_7;
            add_item(op, pick_value(), pick_pos(op));
        end
    endtask

    task automatic add_noise_run(input int unsigned n);
        repeat (n)
            add_item(oale_pkg::OP_W'($urandom_range(0, 7)), $urandom,
                     oale_pkg::POS_W'($urandom_range(0, 127)));
    endtask

    // Sender: present the head of the queue; hold it until it is taken.
    int unsigned s_gap_left   = 0;
    int unsigned s_quiet_left = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_quiet_left > 0)
                s_quiet_left--;
            else if ($urandom_range(0, 63) == 0)
                s_quiet_left = $urandom_range(30, 120);

            if (offer_open) begin
                // hold the beat on the bus until the block takes it
            end else if (s_gap_left > 0) begin
                s_gap_left--;
                s_tvalid <= 1'b0;
            end else if (stim_queue.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (accepted_beats + CALM_TAIL < stim_total && s_quiet_left == 0
                         && $urandom_range(0, 4) == 0) begin
                s_gap_left = $urandom_range(0, 15);
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid   <= 1'b1;
                s_tdata    <= {1'b0, stim_queue[0].pos, stim_queue[0].value};
                s_tuser    <= stim_queue[0].op;
                offer_open = 1'b1;
            end
        end
    end

    // Receiver: random stalls, quiet stretches, and the long hold-off.
    int unsigned m_stall_left = 0;
    int unsigned m_quiet_left = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (m_quiet_left > 0)
                m_quiet_left--;
            else if ($urandom_range(0, 63) == 0)
                m_quiet_left = $urandom_range(30, 120);

            if (hold_off) begin
                m_tready <= 1'b0;
            end else if (m_stall_left > 0) begin
                m_stall_left--;
                m_tready <= 1'b0;
            end else if (accepted_beats + CALM_TAIL < stim_total && m_quiet_left == 0
                         && $urandom_range(0, 5) == 0) begin
                m_stall_left = $urandom_range(0, 15);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Hold off the receiver long enough for the block to back up its input.
    initial begin
        while (accepted_beats < 40)
            @(posedge aclk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off = 1'b0;
    end

    // Monitor: predict on every input beat, check every output beat.
    always @(posedge aclk) begin
        list_item_t   it;
        list_result_t got;
        list_result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                it = '{op: s_tuser, value: s_tdata[31:0], pos: s_tdata[38:32]};
                result_queue.push_back(list_apply(CHK_SIDE, it));
                if (shadow_len[CHK_SIDE] > peak_len)
                    peak_len = shadow_len[CHK_SIDE];
                void'(stim_queue.pop_front());
                offer_open = 1'b0;
                accepted_beats++;
            end
            if (m_tvalid && m_tready) begin
                got = '{status: m_tuser, data: m_tdata[31:0],
                        found: m_tdata[38:32], count: m_tdata[45:39]};
                status_seen[got.status]++;
                checked_beats++;
                if (result_queue.size() == 0) begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("unexpected result beat: status %0d data %h found %0d count %0d",
                                 got.status, got.data, got.found, got.count);
                    mismatch_count++;
                end else begin
                    want = result_queue.pop_front();
                    if (got != want) begin
                        if (mismatch_count < REPORT_LIMIT) begin
                            $display("result %0d mismatch (expected/actual): status %0d/%0d",
                                     checked_beats, want.status, got.status);
                            $display("    data %h/%h found %0d/%0d count %0d/%0d",
                                     want.data, got.data, want.found, got.found,
                                     want.count, got.count);
                        end
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        shadow_len[GEN_SIDE] = 0;
        shadow_len[CHK_SIDE] = 0;

        // Directed: empty list, bad positions, extreme words, edges of the list
        add_item(oale_pkg::OP_READ,   '0,            7'd1);
        add_item(oale_pkg::OP_SEARCH, '0,            7'd0);
        add_item(oale_pkg::OP_DELETE, 32'd5,         7'd0);
        add_item(oale_pkg::OP_INSERT, 32'd1,         7'd0);
        add_item(oale_pkg::OP_INSERT, 32'd1,         7'd2);
        add_item(oale_pkg::OP_INSERT, 32'h7FFF_FFFF, 7'd1);
        add_item(oale_pkg::OP_APPEND, 32'h8000_0000, 7'd127);
        add_item(oale_pkg::OP_APPEND, 32'h0000_0000, 7'd0);
        add_item(oale_pkg::OP_APPEND, 32'hFFFF_FFFF, 7'd64);
        add_item(oale_pkg::OP_INSERT, 32'h1234_5678, 7'd2);
        add_item(oale_pkg::OP_INSERT, 32'h0000_0055, 7'd6);
        add_item(oale_pkg::OP_READ,   '0,            7'd1);
        add_item(oale_pkg::OP_READ,   '0,            7'd6);
        add_item(oale_pkg::OP_READ,   '0,            7'd7);
        add_item(oale_pkg::OP_READ,   32'hFFFF_FFFF, 7'd127);
        add_item(oale_pkg::OP_READ,   '0,            7'd0);
        add_item(oale_pkg::OP_SEARCH, 32'h8000_0000, 7'd0);
        add_item(oale_pkg::OP_SEARCH, 32'd1,         7'd0);
        add_item(oale_pkg::OP_APPEND, 32'h0000_0000, 7'd0);
        add_item(oale_pkg::OP_DELETE, 32'h0000_0000, 7'd0);
        add_item(oale_pkg::OP_DELETE, 32'h7FFF_FFFF, 7'd0);
        add_item(oale_pkg::OP_DELETE, 32'hDEAD_BEEF, 7'd0);
        add_item(OP_SPARE_6,          32'hFFFF_FFFF, 7'd127);
        add_item(OP_SPARE_7,          32'h0000_0000, 7'd0);
        add_item(oale_pkg::OP_CLEAR,  32'hFFFF_FFFF, 7'd127);
        add_item(oale_pkg::OP_READ,   '0,            7'd1);

        // Random: one fill up front, then a mix of runs
        add_fill_run();
        while (stim_queue.size() < RANDOM_ITEMS) begin
            case ($urandom_range(0, 19))
                0, 1:    add_fill_run();
                2, 3:    add_noise_run($urandom_range(5, 15));
                4:       add_item(oale_pkg::OP_CLEAR, $urandom,
                                  oale_pkg::POS_W'($urandom_range(0, 127)));
                default: add_mixed_run($urandom_range(10, 30));
            endcase
        end
        stim_total = stim_queue.size();

        // Hold reset, then release it on a falling edge
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Drain: every beat taken, every result back, then let the block settle
        while (accepted_beats < stim_total || result_queue.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d beats, checked %0d results, peak list length %0d",
                 stim_total, checked_beats, peak_len);
        $display("status mix: ok %0d, not found %0d, full %0d, bad position %0d",
                 status_seen[oale_pkg::ST_OK], status_seen[oale_pkg::ST_NOTFOUND],
                 status_seen[oale_pkg::ST_FULL], status_seen[oale_pkg::ST_BADPOS]);
        if (mismatch_count == 0 && result_queue.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("mismatches: %0d", mismatch_count);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
